### hw/rtl/imhq_pkg.sv
// Package for the indexed min-heap queue: modes, status codes, limits, helpers.
// Used by the controller, datapath, top level and checker.
package imhq_pkg;
   localparam int MaxElemsDefault = 255;
   localparam int IdW  = 8;
   localparam int KeyW = 32;
   localparam int SlotW = 8;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_BADID = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE, CMD_CLEAR, CMD_LATCH, CMD_START_UPD, CMD_START_NEW, CMD_RD_TOP,
      CMD_RM_LAST, CMD_RM_GET, CMD_RD_PARENT, CMD_UP_STEP, CMD_RD_LEFT,
      CMD_RD_RIGHT, CMD_DN_STEP, CMD_PLACE, CMD_RD_ELEM, CMD_LATCH_ELEM
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    set_status;
   } dp_ctrl_type;

   typedef struct packed {
      logic clear_done;
      logic up_go;     // parent key strictly greater
      logic at_root;
      logic dn_has_l;
      logic dn_go;     // chosen child strictly less
      logic id_ok;
      logic present;
      logic empty;
      logic full;
      logic [1:0] mode;
   } dp_stat_type;

   function automatic logic key_lt(input logic signed [KeyW-1:0] a,
                                   input logic signed [KeyW-1:0] b);
      key_lt = a < b;
   endfunction
endpackage

### hw/rtl/imhq_datapath.sv
// Datapath of the min-heap queue: slot memories, position memory, sift registers.
// Depends on imhq_pkg; steered by imhq_ctrl.
module imhq_datapath #(
   parameter int MAX_ELEMS = imhq_pkg::MaxElemsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  imhq_pkg::dp_ctrl_type         ctrl,
   input  logic [1:0]                    req_mode,
   input  logic [imhq_pkg::IdW-1:0]      req_element_id,
   input  logic signed [imhq_pkg::KeyW-1:0] req_priority_value,
   output imhq_pkg::dp_stat_type         stat,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_queue_empty,
   output logic [imhq_pkg::IdW-1:0]      rsp_top_element,
   output logic signed [imhq_pkg::KeyW-1:0] rsp_top_priority,
   output logic                          rsp_element_present,
   output logic signed [imhq_pkg::KeyW-1:0] rsp_element_priority
);
   import imhq_pkg::*;
   localparam int Limit = (MAX_ELEMS < 255) ? MAX_ELEMS : 255;

   logic [IdW-1:0]   id_mem  [256];
   logic [KeyW-1:0]  key_mem [256];
   logic [SlotW-1:0] pos_mem [256];

   logic [1:0]       mode_ff;
   logic [IdW-1:0]   id_ff;
   logic [KeyW-1:0]  val_ff;
   logic [SlotW-1:0] fill_ff, fill_in;
   logic [SlotW-1:0] s_ff, s_in;           // current hole slot
   logic [IdW-1:0]   mid_ff, mid_in;        // element being sifted
   logic [KeyW-1:0]  mkey_ff, mkey_in;
   logic [IdW-1:0]   cid_ff;                // left child held for compare
   logic [KeyW-1:0]  ckey_ff;
   logic [SlotW-1:0] clr_ff;
   logic [SlotW-1:0] pos_rd_ff;
   logic [IdW-1:0]   rd_id_ff;
   logic [KeyW-1:0]  rd_key_ff;
   logic [IdW-1:0]   top_id_ff;
   logic [KeyW-1:0]  top_key_ff;
   logic [KeyW-1:0]  elem_key_ff;
   logic [1:0]       status_ff, status_in;

   logic [SlotW-1:0] rd_addr;
   logic             slot_we;
   logic [IdW-1:0]   slot_wid;
   logic [KeyW-1:0]  slot_wkey;
   logic             pos_we;
   logic [IdW-1:0]   pos_waddr;
   logic [SlotW-1:0] pos_wdata;
   logic [8:0]       lchild, rchild;
   logic             has_r, pick_r, id_ok;
   logic [IdW-1:0]   sel_id;
   logic [KeyW-1:0]  sel_key;
   logic [SlotW-1:0] sel_slot;

   assign lchild = {s_ff, 1'b0};
   assign rchild = {s_ff, 1'b1};
   assign id_ok = (id_ff != '0) && ({1'b0, id_ff} <= 9'(Limit));
   assign has_r = ({1'b0, fill_ff} >= rchild);

   // right child wins only when strictly less than the left one
   assign pick_r   = has_r && key_lt(rd_key_ff, ckey_ff);
   assign sel_id   = pick_r ? rd_id_ff : cid_ff;
   assign sel_key  = pick_r ? rd_key_ff : ckey_ff;
   assign sel_slot = pick_r ? rchild[SlotW-1:0] : lchild[SlotW-1:0];

   always_comb begin
      case (ctrl.cmd)
         CMD_RD_TOP:    rd_addr = SlotW'(1);
         CMD_RM_LAST:   rd_addr = fill_ff;
         CMD_RD_PARENT: rd_addr = s_ff >> 1;
         CMD_RD_LEFT:   rd_addr = lchild[SlotW-1:0];
         CMD_RD_RIGHT:  rd_addr = rchild[SlotW-1:0];
         CMD_RD_ELEM:   rd_addr = pos_rd_ff;
         default:       rd_addr = s_ff;
      endcase
   end

   always_comb begin
      slot_we = 1'b0;
      slot_wid = mid_ff;
      slot_wkey = mkey_ff;
      pos_we = 1'b0;
      pos_waddr = mid_ff;
      pos_wdata = s_ff;
      case (ctrl.cmd)
         CMD_CLEAR: begin
            pos_we = 1'b1;
            pos_waddr = clr_ff;
            pos_wdata = '0;
         end
         CMD_RM_LAST: begin
            // old top leaves the queue
            pos_we = 1'b1;
            pos_waddr = rd_id_ff;
            pos_wdata = '0;
         end
         CMD_UP_STEP: begin
            slot_we = 1'b1;
            slot_wid = rd_id_ff;
            slot_wkey = rd_key_ff;
            pos_we = 1'b1;
            pos_waddr = rd_id_ff;
         end
         CMD_DN_STEP: begin
            slot_we = 1'b1;
            slot_wid = sel_id;
            slot_wkey = sel_key;
            pos_we = 1'b1;
            pos_waddr = sel_id;
         end
         CMD_PLACE: begin
            slot_we = 1'b1;
            pos_we = 1'b1;
         end
         default: ;
      endcase
   end

   // slot store, one read and one write port, registered read
   always_ff @(posedge clock) begin
      rd_id_ff  <= id_mem[rd_addr];
      rd_key_ff <= key_mem[rd_addr];
      if (slot_we) begin
         id_mem[s_ff]  <= slot_wid;
         key_mem[s_ff] <= slot_wkey;
      end
   end

   // position store: write a moved id, read the named id every cycle
   always_ff @(posedge clock) begin
      pos_rd_ff <= pos_mem[id_ff];
      if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
   end

   always_comb begin
      s_in = s_ff; mid_in = mid_ff; mkey_in = mkey_ff; fill_in = fill_ff;
      case (ctrl.cmd)
         CMD_START_UPD: begin
            s_in = pos_rd_ff; mid_in = id_ff; mkey_in = val_ff;
         end
         CMD_START_NEW: begin
            fill_in = fill_ff + 1'b1; s_in = fill_ff + 1'b1;
            mid_in = id_ff; mkey_in = val_ff;
         end
         CMD_RM_LAST: fill_in = fill_ff - 1'b1;
         CMD_RM_GET: begin
            // last element restarts from the root
            s_in = SlotW'(1); mid_in = rd_id_ff; mkey_in = rd_key_ff;
         end
         CMD_UP_STEP: s_in = s_ff >> 1;
         CMD_DN_STEP: s_in = sel_slot;
         default: ;
      endcase
   end

   always_comb begin
      if (mode_ff == MODE_REMOVE) status_in = (fill_ff == '0) ? STAT_EMPTY : STAT_DONE;
      else status_in = id_ok ? STAT_DONE : STAT_BADID;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0; clr_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         if (ctrl.cmd == CMD_CLEAR) clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in; mid_ff <= mid_in; mkey_ff <= mkey_in;
      if (ctrl.cmd == CMD_LATCH) begin
         mode_ff <= req_mode;
         id_ff <= req_element_id; val_ff <= req_priority_value;
      end
      if (ctrl.set_status) status_ff <= status_in;
      if (ctrl.cmd == CMD_RD_RIGHT) begin
         cid_ff <= rd_id_ff; ckey_ff <= rd_key_ff;
      end
      if (ctrl.cmd == CMD_RD_ELEM) begin
         top_id_ff <= rd_id_ff; top_key_ff <= rd_key_ff;
      end
      if (ctrl.cmd == CMD_LATCH_ELEM) elem_key_ff <= rd_key_ff;
   end

   always_comb begin
      stat.clear_done = (clr_ff == '1);
      stat.at_root  = (s_ff == SlotW'(1));
      stat.up_go    = key_lt(mkey_ff, rd_key_ff);
      stat.dn_has_l = ({1'b0, fill_ff} >= lchild);
      stat.dn_go    = key_lt(sel_key, mkey_ff);
      stat.id_ok    = id_ok;
      stat.present  = (pos_rd_ff != '0);
      stat.empty    = (fill_ff == '0);
      stat.full     = (fill_ff == '1);
      stat.mode     = mode_ff;
   end

   assign rsp_status = status_ff;
   assign rsp_queue_empty = (fill_ff == '0);
   assign rsp_top_element = (fill_ff == '0) ? '0 : top_id_ff;
   assign rsp_top_priority = (fill_ff == '0) ? '0 : top_key_ff;
   assign rsp_element_present = id_ok && (pos_rd_ff != '0);
   assign rsp_element_priority = rsp_element_present ? elem_key_ff : '0;
endmodule

### hw/rtl/imhq_ctrl.sv
// Controller of the min-heap queue: sequences reads, compares and writes of a sift.
// Depends on imhq_pkg; drives imhq_datapath.
module imhq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   input  imhq_pkg::dp_stat_type stat,
   output imhq_pkg::dp_ctrl_type ctrl
);
   import imhq_pkg::*;

   typedef enum logic [15:0] {
      S_CLEAR   = 16'h0001, S_IDLE   = 16'h0002, S_POS    = 16'h0004,
      S_DISP    = 16'h0008, S_RM_LAST = 16'h0010, S_RM_GET = 16'h0020,
      S_UP_RD   = 16'h0040, S_UP_CMP = 16'h0080, S_DN_L   = 16'h0100,
      S_DN_R    = 16'h0200, S_DN_CMP = 16'h0400, S_PLACE  = 16'h0800,
      S_RPT     = 16'h1000, S_RPT_W  = 16'h2000, S_RPT_E  = 16'h4000,
      S_DONE    = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic upd_ff, upd_in;

   always_comb begin
      state_in = state_ff; upd_in = upd_ff;
      ctrl.cmd = CMD_NONE; ctrl.set_status = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ctrl.cmd = CMD_CLEAR;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               ctrl.cmd = CMD_LATCH; state_in = S_POS;
            end
         end
         S_POS: state_in = S_DISP;   // position store read settles
         S_DISP: begin
            ctrl.set_status = 1'b1;
            upd_in = 1'b0;
            state_in = S_RPT;
            if (stat.mode == MODE_INSERT && stat.id_ok) begin
               if (stat.present) begin
                  ctrl.cmd = CMD_START_UPD; upd_in = 1'b1; state_in = S_UP_RD;
               end else if (!stat.full) begin
                  ctrl.cmd = CMD_START_NEW; state_in = S_UP_RD;
               end
            end else if (stat.mode == MODE_REMOVE && !stat.empty) begin
               ctrl.cmd = CMD_RD_TOP; state_in = S_RM_LAST;
            end
         end
         // remove: drop top id, fetch last slot, sink it from the root
         S_RM_LAST: begin
            ctrl.cmd = CMD_RM_LAST; state_in = S_RM_GET;
         end
         S_RM_GET: begin
            ctrl.cmd = CMD_RM_GET;
            state_in = stat.empty ? S_RPT : S_DN_L;
         end
         // sift up
         S_UP_RD: begin
            if (stat.at_root) state_in = upd_ff ? S_DN_L : S_PLACE;
            else begin
               ctrl.cmd = CMD_RD_PARENT; state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_go) begin
               ctrl.cmd = CMD_UP_STEP; state_in = S_UP_RD;
            end else state_in = upd_ff ? S_DN_L : S_PLACE;
         end
         // sift down
         S_DN_L: begin
            if (!stat.dn_has_l) state_in = S_PLACE;
            else begin
               ctrl.cmd = CMD_RD_LEFT; state_in = S_DN_R;
            end
         end
         S_DN_R: begin
            ctrl.cmd = CMD_RD_RIGHT; state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.dn_go) begin
               ctrl.cmd = CMD_DN_STEP; state_in = S_DN_L;
            end else state_in = S_PLACE;
         end
         S_PLACE: begin
            ctrl.cmd = CMD_PLACE; state_in = S_RPT;
         end
         S_RPT: begin
            ctrl.cmd = CMD_RD_TOP; state_in = S_RPT_W;
         end
         S_RPT_W: begin
            ctrl.cmd = CMD_RD_ELEM; state_in = S_RPT_E;
         end
         S_RPT_E: begin
            ctrl.cmd = CMD_LATCH_ELEM; state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; upd_ff <= 1'b0;
      end else begin
         state_ff <= state_in; upd_ff <= upd_in;
      end
   end
endmodule

### hw/rtl/indexed_min_heap_queue.sv
// Top level of the indexed min-heap priority queue.
// Depends on imhq_pkg, imhq_ctrl and imhq_datapath.
//
// Indexed binary min-heap over ids 1..MAX_ELEMS (at most 255), signed Q16.16 keys.
// After reset a clearing pass empties the position store; busy is high through it.
// A transfer is taken when start is high and busy is low. A query, a rejected id or a
// remove on an empty queue goes straight to the report; an insert also rises level by
// level, an update rises and then sinks, and a remove sinks from the root. The pace is
// set by the slot memory's single registered read port: every compare waits for its
// read. The result is shown for one cycle on rsp_valid and cannot be stalled.
module indexed_min_heap_queue #(
   parameter int MAX_ELEMS = imhq_pkg::MaxElemsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_mode,
   input  logic [imhq_pkg::IdW-1:0] req_element_id,
   input  logic signed [imhq_pkg::KeyW-1:0] req_priority_value,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic rsp_queue_empty,
   output logic [imhq_pkg::IdW-1:0] rsp_top_element,
   output logic signed [imhq_pkg::KeyW-1:0] rsp_top_priority,
   output logic rsp_element_present,
   output logic signed [imhq_pkg::KeyW-1:0] rsp_element_priority
);
   import imhq_pkg::*;
   dp_ctrl_type ctrl;
   dp_stat_type stat;

   imhq_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .rsp_valid, .stat, .ctrl
   );

   imhq_datapath #(.MAX_ELEMS(MAX_ELEMS)) u_dp (
      .clock, .reset, .ctrl, .req_mode, .req_element_id, .req_priority_value,
      .stat, .rsp_status, .rsp_queue_empty, .rsp_top_element, .rsp_top_priority,
      .rsp_element_present, .rsp_element_priority
   );
endmodule

### hw/rtl/imhq_checker.sv
// Port-level checker for the min-heap queue, bound to the top level.
// Depends on imhq_pkg.
module imhq_checker (
   input logic clock, input logic reset, input logic start, input logic busy,
   input logic rsp_valid, input logic [1:0] rsp_status, input logic rsp_queue_empty,
   input logic [7:0] rsp_top_element, input logic rsp_element_present
);
   import imhq_pkg::*;
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside item");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("no return to idle");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("transfer not taken");
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_empty |-> rsp_top_element == '0) else $error("empty top");
   a_bad_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_BADID |-> !rsp_element_present)
      else $error("bad id reported present");
endmodule

bind indexed_min_heap_queue imhq_checker u_chk (.*);
